@@ sv/key_value_table_store_core_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef KEY_VALUE_TABLE_STORE_CORE_DEFINES_SVH
`define KEY_VALUE_TABLE_STORE_CORE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define KVTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define KVTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kvts_pkg.sv @@
package kvts_pkg;

  localparam int unsigned HI_W  = 56;
  localparam int unsigned LO_W  = 64;
  localparam int unsigned STR_W = HI_W + LO_W;
  localparam int unsigned STR_BYTES = STR_W / 8;

  typedef logic [STR_W-1:0] str_t;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_GET  = 2'd1,
    ACT_LIST = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_FULL       = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_LIST_ENTRY = 3'd4,
    ST_LIST_EMPTY = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_MISS,
    S_EMIT
  } state_e;

  // Zero every byte from the first zero byte on.
  function automatic str_t kvts_canon(input str_t s);
    logic ended;
    str_t r;
    ended = 1'b0;
    r     = '0;
    for (int i = 0; i < STR_BYTES; i++) begin
      if (s[STR_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[STR_W-1-8*i -: 8] = s[STR_W-1-8*i -: 8];
    end
    return r;
  endfunction

endpackage

@@ sv/key_value_table_store_core.sv @@
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  action, key_high/low, value_high/low
// out      output     out_valid_o / out_stall_i status, out_key/out_value high/low, last
//
// One request at a time; the table is scanned entry by entry, a read and a
// compare state each, through a single registered read port of the key and
// value memories. Set and get stop at the match or pass a miss state; list
// emits each entry in turn, or one empty result on an empty table.
// Reset clears the state machine and the entry count; memories hold no reset.
// A stalled output holds the result and the scan and adds its stall cycles.
module key_value_table_store_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic [kvts_pkg::HI_W-1:0] key_high_i,
  input  logic [kvts_pkg::LO_W-1:0] key_low_i,
  input  logic [kvts_pkg::HI_W-1:0] value_high_i,
  input  logic [kvts_pkg::LO_W-1:0] value_low_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [kvts_pkg::HI_W-1:0] out_key_high_o,
  output logic [kvts_pkg::LO_W-1:0] out_key_low_o,
  output logic [kvts_pkg::HI_W-1:0] out_value_high_o,
  output logic [kvts_pkg::LO_W-1:0] out_value_low_o,
  output logic                     last_o
);
  import kvts_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  state_e             state_q, state_d;
  action_e            act_q, act_d;
  str_t               key_q, key_d;
  str_t               val_q, val_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  status_e            status_q, status_d;
  str_t               okey_q, okey_d;
  str_t               oval_q, oval_d;
  logic               last_q, last_d;

  str_t               key_mem [ENTRIES];
  str_t               val_mem [ENTRIES];
  str_t               rd_key_q;
  str_t               rd_val_q;
  logic               key_we;
  logic               val_we;
  logic [IDX_W-1:0]   waddr;

  logic               in_acc;
  logic               out_acc;
  logic               match;
  logic               full;
  logic               at_end;
  logic [CNT_W-1:0]   idx_next;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign match    = (rd_key_q == key_q);
  assign full     = (count_q == CNT_W'(ENTRIES));
  assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
  assign at_end   = (idx_next == count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(action_i))
            ACT_NONE: state_d = S_IDLE;
            ACT_LIST: state_d = (count_q == '0) ? S_EMIT : S_READ;
            ACT_SET,
            ACT_GET:  state_d = (count_q == '0) ? S_MISS : S_READ;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        priority if (act_q == ACT_LIST || match) state_d = S_EMIT;
        else if (at_end)                         state_d = S_MISS;
        else                                     state_d = S_READ;
      end
      S_MISS: state_d = S_EMIT;
      S_EMIT: begin
        if (out_acc) state_d = (act_q == ACT_LIST && !last_q) ? S_READ : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_EMIT);
  end

  always_comb begin
    act_d    = act_q;
    key_d    = key_q;
    val_d    = val_q;
    idx_d    = idx_q;
    count_d  = count_q;
    status_d = status_q;
    okey_d   = okey_q;
    oval_d   = oval_q;
    last_d   = last_q;
    key_we   = 1'b0;
    val_we   = 1'b0;
    waddr    = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d    = action_e'(action_i);
          key_d    = kvts_canon({key_high_i, key_low_i});
          val_d    = kvts_canon({value_high_i, value_low_i});
          idx_d    = '0;
          status_d = ST_LIST_EMPTY;
          okey_d   = '0;
          oval_d   = '0;
          last_d   = 1'b1;
        end
      end
      S_CMP: begin
        okey_d = rd_key_q;
        oval_d = rd_val_q;
        last_d = 1'b1;
        priority if (act_q == ACT_LIST) begin
          status_d = ST_LIST_ENTRY;
          last_d   = at_end;
        end else if (match && act_q == ACT_GET) begin
          status_d = ST_FOUND;
        end else if (match) begin
          status_d = ST_STORED;
          oval_d   = val_q;
          val_we   = 1'b1;
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_MISS: begin
        okey_d = key_q;
        oval_d = val_q;
        last_d = 1'b1;
        waddr  = count_q[IDX_W-1:0];
        priority if (act_q == ACT_GET) begin
          status_d = ST_NOT_FOUND;
          oval_d   = '0;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_STORED;
          key_we   = 1'b1;
          val_we   = 1'b1;
          count_d  = count_q + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_acc) idx_d = idx_next[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    okey_q   <= okey_d;
    oval_q   <= oval_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[waddr] <= key_q;
    if (val_we) val_mem[waddr] <= val_q;
    rd_key_q <= key_mem[idx_q];
    rd_val_q <= val_mem[idx_q];
  end

  assign status_o         = status_q;
  assign out_key_high_o   = okey_q[STR_W-1 -: HI_W];
  assign out_key_low_o    = okey_q[LO_W-1:0];
  assign out_value_high_o = oval_q[STR_W-1 -: HI_W];
  assign out_value_low_o  = oval_q[LO_W-1:0];
  assign last_o           = last_q;

endmodule

@@ sv/kvts_checker.sv @@
`include "key_value_table_store_core_defines.svh"

module kvts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [1:0]                action_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [2:0]                status_o,
  input logic [kvts_pkg::HI_W-1:0] out_key_high_o,
  input logic [kvts_pkg::LO_W-1:0] out_key_low_o,
  input logic [kvts_pkg::HI_W-1:0] out_value_high_o,
  input logic [kvts_pkg::LO_W-1:0] out_value_low_o,
  input logic                      last_o
);
  import kvts_pkg::*;

  `KVTS_ASSERT_NOW(a_no_accept_while_result, out_valid_o, in_stall_o, "item taken while result pending")
  `KVTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(last_o) && $stable(out_key_low_o), "stalled result changed")
  `KVTS_ASSERT_NEXT(a_ignore_unused, in_valid_i && !in_stall_o && action_i == ACT_NONE, !in_stall_o && !out_valid_o, "unused request not ignored")
  `KVTS_ASSERT_NOW(a_single_last, out_valid_o && status_o != ST_LIST_ENTRY, last_o, "single result without last")
  `KVTS_ASSERT_NOW(a_empty_zero, out_valid_o && status_o == ST_LIST_EMPTY, out_key_high_o == '0 && out_key_low_o == '0 && out_value_high_o == '0 && out_value_low_o == '0, "list empty with data")

endmodule

bind key_value_table_store_core kvts_checker u_kvts_checker (.*);
